// File: design/sssp_pkg.sv
// Shared types and constants for the single-source shortest paths block.
// Used by the controller, the datapath and the top level; depends on nothing.
package sssp_pkg;

    localparam int MAX_NODES   = 64;
    localparam int NODE_BITS   = $clog2(MAX_NODES);
    localparam int COUNT_BITS  = NODE_BITS + 1;
    localparam int WEIGHT_BITS = 16;
    localparam int DIST_BITS   = 22;
    localparam int ADJ_DEPTH   = MAX_NODES * MAX_NODES;
    localparam int ADJ_ABITS   = 2 * NODE_BITS;
    localparam int CFG_BITS    = 7;

    localparam logic [DIST_BITS-1:0]  DIST_MAX      = '1;
    localparam logic [COUNT_BITS-1:0] NODE_COUNT_RST = COUNT_BITS'(MAX_NODES);

    // configuration register indexes
    localparam logic CFG_NODE_COUNT  = 1'b0;
    localparam logic CFG_SOURCE_NODE = 1'b1;

    typedef struct packed {
        logic [5:0]  node_a;
        logic [5:0]  node_b;
        logic [15:0] edge_weight;
        logic        last_edge;
    } t_edge_in;

    typedef struct packed {
        logic [5:0]  node_index;
        logic [21:0] distance;
        logic        reachable;
        logic        last_result;
    } t_result;

    typedef struct packed {
        logic                   vld;
        logic [WEIGHT_BITS-1:0] w;
    } t_adj;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_CLEAR,
        OP_EDGE_WR1,
        OP_EDGE_WR2,
        OP_INIT,
        OP_SCAN,
        OP_SCAN_WAIT,
        OP_DECIDE,
        OP_RELAX,
        OP_RELAX_WAIT,
        OP_OUT,
        OP_OUT_WAIT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic accept;
    } t_cmd;

    typedef struct packed {
        logic last_node;
        logic last_cell;
        logic found;
        logic last_edge;
    } t_status;

endpackage

// File: design/sssp_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sssp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/sssp_ctrl.sv
// Sequencer for edge load, array-scan solve, result readout and store clearing.
// Depends on sssp_pkg; drives the datapath through t_cmd and reads t_status.
module sssp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  sssp_pkg::t_status i_status,
    output sssp_pkg::t_cmd    o_cmd,
    output logic              o_busy
);
    import sssp_pkg::*;

    typedef enum logic [11:0] {
        S_CLEAR      = 12'b0000_0000_0001,
        S_IDLE       = 12'b0000_0000_0010,
        S_EDGE_WR1   = 12'b0000_0000_0100,
        S_EDGE_WR2   = 12'b0000_0000_1000,
        S_INIT       = 12'b0000_0001_0000,
        S_SCAN       = 12'b0000_0010_0000,
        S_SCAN_WAIT  = 12'b0000_0100_0000,
        S_DECIDE     = 12'b0000_1000_0000,
        S_RELAX      = 12'b0001_0000_0000,
        S_RELAX_WAIT = 12'b0010_0000_0000,
        S_OUT        = 12'b0100_0000_0000,
        S_OUT_WAIT   = 12'b1000_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd.op     = OP_IDLE;
        o_cmd.accept = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                if (i_status.last_cell) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_cmd.op = OP_IDLE;
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EDGE_WR1;
                end
            end
            S_EDGE_WR1: begin
                o_cmd.op = OP_EDGE_WR1;
                n_state  = S_EDGE_WR2;
            end
            S_EDGE_WR2: begin
                o_cmd.op = OP_EDGE_WR2;
                n_state  = i_status.last_edge ? S_INIT : S_IDLE;
            end
            S_INIT: begin
                o_cmd.op = OP_INIT;
                n_state  = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.op = OP_SCAN;
                if (i_status.last_node) n_state = S_SCAN_WAIT;
            end
            S_SCAN_WAIT: begin
                o_cmd.op = OP_SCAN_WAIT;
                n_state  = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.op = OP_DECIDE;
                n_state  = i_status.found ? S_RELAX : S_OUT;
            end
            S_RELAX: begin
                o_cmd.op = OP_RELAX;
                if (i_status.last_node) n_state = S_RELAX_WAIT;
            end
            S_RELAX_WAIT: begin
                o_cmd.op = OP_RELAX_WAIT;
                n_state  = S_SCAN;
            end
            S_OUT: begin
                o_cmd.op = OP_OUT;
                if (i_status.last_node) n_state = S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
                o_cmd.op = OP_OUT_WAIT;
                n_state  = S_CLEAR;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// File: design/sssp_dp.sv
// Datapath: configuration, adjacency and distance memories, settled and valid
// flags, scan minimum and relaxation. Depends on sssp_pkg and sssp_ram.
module sssp_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sssp_pkg::t_cmd       i_cmd,
    output sssp_pkg::t_status    o_status,
    input  sssp_pkg::t_edge_in   i_edge,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [6:0]           i_cfg_data,
    output logic                 o_result_valid,
    output sssp_pkg::t_result    o_result
);
    import sssp_pkg::*;

    // configuration
    logic [COUNT_BITS-1:0] r_node_count;
    logic [NODE_BITS-1:0]  r_source;
    logic [COUNT_BITS-1:0] eff_n;
    logic [COUNT_BITS-1:0] n_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RST;
            r_source     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_NODE_COUNT:  r_node_count <= i_cfg_data[COUNT_BITS-1:0];
                CFG_SOURCE_NODE: r_source     <= i_cfg_data[NODE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        priority if (r_node_count == '0) begin
            eff_n = COUNT_BITS'(1);
        end else if (r_node_count > NODE_COUNT_RST) begin
            eff_n = NODE_COUNT_RST;
        end else begin
            eff_n = r_node_count;
        end
    end
    assign n_last = eff_n - COUNT_BITS'(1);

    // captured edge
    logic [NODE_BITS-1:0]   r_a, r_b;
    logic [WEIGHT_BITS-1:0] r_w;
    logic                   r_last, r_upd;
    logic                   edge_ok, upd;

    // scan index and its registered copy for the registered reads
    logic [ADJ_ABITS-1:0] r_idx;
    logic [NODE_BITS-1:0] r_pidx;
    t_op                  r_pop;
    logic                 issue;

    // solve state
    logic [MAX_NODES-1:0] r_settled, r_tvalid;
    logic [DIST_BITS-1:0] r_best;
    logic [NODE_BITS-1:0] r_pick;
    logic                 r_found;

    // memories
    t_adj                 adj_q, adj_wdata;
    logic                 adj_we;
    logic [ADJ_ABITS-1:0] adj_waddr, adj_raddr;
    logic [DIST_BITS-1:0] tent_q, tent_wdata;
    logic                 tent_we;
    logic [NODE_BITS-1:0] tent_waddr;

    logic [DIST_BITS:0]   sum;
    logic [DIST_BITS-1:0] relax_d;
    logic                 relax_hit, scan_hit;

    assign edge_ok = ({1'b0, r_a} < eff_n) && ({1'b0, r_b} < eff_n);
    assign upd     = edge_ok && (!adj_q.vld || (r_w < adj_q.w));
    assign issue   = (i_cmd.op == OP_SCAN) || (i_cmd.op == OP_RELAX) ||
                     (i_cmd.op == OP_OUT) || (i_cmd.op == OP_CLEAR);

    assign sum     = {1'b0, r_best} + (DIST_BITS + 1)'(adj_q.w);
    assign relax_d = sum[DIST_BITS] ? DIST_MAX : sum[DIST_BITS-1:0];
    assign relax_hit = (r_pop == OP_RELAX) && adj_q.vld && !r_settled[r_pidx] &&
                       (!r_tvalid[r_pidx] || (relax_d < tent_q));
    assign scan_hit  = (r_pop == OP_SCAN) && !r_settled[r_pidx] && r_tvalid[r_pidx] &&
                       (!r_found || (tent_q < r_best));

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_a    <= i_edge.node_a;
            r_b    <= i_edge.node_b;
            r_w    <= i_edge.edge_weight[WEIGHT_BITS-1:0];
            r_last <= i_edge.last_edge;
        end
        if (i_cmd.op == OP_EDGE_WR1) begin
            r_upd <= upd;
        end
        r_pidx <= r_idx[NODE_BITS-1:0];
        if (scan_hit) begin
            r_best <= tent_q;
            r_pick <= r_pidx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_pop     <= OP_IDLE;
            r_found   <= 1'b0;
            r_settled <= '0;
            r_tvalid  <= '0;
        end else begin
            r_idx <= issue ? r_idx + ADJ_ABITS'(1) : '0;
            r_pop <= i_cmd.op;
            // hold the running minimum only across one scan
            if (scan_hit) begin
                r_found <= 1'b1;
            end else if (i_cmd.op != OP_SCAN && i_cmd.op != OP_SCAN_WAIT) begin
                r_found <= 1'b0;
            end
            if (i_cmd.op == OP_INIT) begin
                r_settled <= '0;
                r_tvalid  <= ({1'b0, r_source} < eff_n) ? (MAX_NODES'(1) << r_source) : '0;
            end else begin
                if (i_cmd.op == OP_DECIDE && r_found) r_settled[r_pick] <= 1'b1;
                if (relax_hit) r_tvalid[r_pidx] <= 1'b1;
            end
        end
    end

    // adjacency store ports
    always_comb begin
        adj_raddr = (i_cmd.op == OP_RELAX) ? {r_pick, r_idx[NODE_BITS-1:0]}
                                           : {i_edge.node_a, i_edge.node_b};
        adj_we    = 1'b0;
        adj_waddr = {r_a, r_b};
        adj_wdata = '{vld: 1'b1, w: r_w};
        unique case (i_cmd.op)
            OP_EDGE_WR1: adj_we = upd;
            OP_EDGE_WR2: begin
                adj_we    = r_upd;
                adj_waddr = {r_b, r_a};
            end
            OP_CLEAR: begin
                adj_we    = 1'b1;
                adj_waddr = r_idx;
                adj_wdata = '0;
            end
            default: ;
        endcase
    end

    sssp_ram #(
        .WIDTH($bits(t_adj)),
        .DEPTH(ADJ_DEPTH)
    ) u_adj_ram (
        .i_clk  (i_clk),
        .i_we   (adj_we),
        .i_waddr(adj_waddr),
        .i_wdata(adj_wdata),
        .i_raddr(adj_raddr),
        .o_rdata(adj_q)
    );

    // tentative distances; a settled node's entry is its final distance
    always_comb begin
        tent_we    = relax_hit;
        tent_waddr = r_pidx;
        tent_wdata = relax_d;
        if (i_cmd.op == OP_INIT) begin
            tent_we    = 1'b1;
            tent_waddr = r_source;
            tent_wdata = '0;
        end
    end

    sssp_ram #(
        .WIDTH(DIST_BITS),
        .DEPTH(MAX_NODES)
    ) u_tent_ram (
        .i_clk  (i_clk),
        .i_we   (tent_we),
        .i_waddr(tent_waddr),
        .i_wdata(tent_wdata),
        .i_raddr(r_idx[NODE_BITS-1:0]),
        .o_rdata(tent_q)
    );

    // result register
    logic    r_res_v;
    t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_v <= 1'b0;
        end else begin
            r_res_v <= (r_pop == OP_OUT);
        end
        r_res.node_index  <= r_pidx;
        r_res.distance    <= r_settled[r_pidx] ? tent_q : '0;
        r_res.reachable   <= r_settled[r_pidx];
        r_res.last_result <= ({1'b0, r_pidx} == n_last);
    end

    assign o_result_valid = r_res_v;
    assign o_result       = r_res;

    assign o_status.last_node = (r_idx == ADJ_ABITS'(n_last));
    assign o_status.last_cell = &r_idx;
    assign o_status.found     = r_found;
    assign o_status.last_edge = r_last;

endmodule

// File: design/single_source_shortest_paths_top.sv
// Single-source shortest paths block, top level.
// Depends on sssp_pkg, sssp_ctrl and sssp_dp.
//
// Usage:
//   Edges come in on i_edge; a beat is taken when start is high and busy low.
//   Edges naming a node at or above the node count (a count of 0 acts as 1)
//   are dropped; a repeated edge keeps its smaller weight. Each edge goes
//   through a read-compare-write of both halves in the single-port-write
//   adjacency memory (states EDGE_WR1, EDGE_WR2); busy stays high until the second half is written.
//   The beat with last_edge set starts the solve: an init step, then per
//   settled node a scan over the nodes, a decide step and a relax pass over
//   the nodes, and a final scan that finds nothing.
//   Results then follow one per cycle, nodes 0..n-1, on o_result, each marked
//   by o_result_valid for one cycle; the receiver cannot stall them.
//   The 4096-entry adjacency memory is then cleared, one entry a cycle,
//   before busy drops. The same clearing pass runs after reset.
//   Configuration (node count, source node) is written through i_cfg_* while
//   busy is low and no item is in flight.
module single_source_shortest_paths_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  sssp_pkg::t_edge_in  i_edge,
    output logic                o_result_valid,
    output sssp_pkg::t_result   o_result,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [6:0]          i_cfg_data
);
    import sssp_pkg::*;

    t_cmd    cmd;
    t_status status;

    sssp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_status(status),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    sssp_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_edge        (i_edge),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_result_valid(o_result_valid),
        .o_result      (o_result)
    );

`ifndef SYNTHESIS
    a_result_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> busy)
        else $error("result beat while idle");

    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("edge beat did not make the block busy");

    a_last_ends_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.last_result) |=> !o_result_valid)
        else $error("result beat after the last result");

    a_unreachable_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.reachable) |-> (o_result.distance == '0))
        else $error("unreachable node with nonzero distance");
`endif

endmodule
